@@ hw/rtl/cleb_pkg.sv @@
`timescale 1ns / 1ps

package cleb_pkg;

    // Action codes carried on the input action field.
    localparam logic [1:0] ACT_KEY   = 2'd0;
    localparam logic [1:0] ACT_READ  = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;

    // Keystroke bytes with a special meaning.
    localparam logic [7:0] KEY_LEFT  = 8'h3C;
    localparam logic [7:0] KEY_RIGHT = 8'h3E;
    localparam logic [7:0] KEY_BACK  = 8'h2D;

    // Result status codes.
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_RANGE = 2'd2;

    // Decoded operation handed from the front end to the executor.
    typedef enum logic [2:0] {
        OP_NOP,
        OP_LEFT,
        OP_RIGHT,
        OP_BACK,
        OP_INSERT,
        OP_READ,
        OP_CLEAR
    } op_t;

    // Executor sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MOVE,
        ST_RDATA
    } state_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] key_byte;
        logic [9:0] position;
    } cmd_t;

    typedef struct packed {
        logic [7:0]  char_out;
        logic [10:0] line_length;
        logic [10:0] cursor_pos;
        logic [1:0]  status;
    } res_t;

endpackage

@@ hw/rtl/cursor_line_edit_buffer_top.sv @@
`timescale 1ns / 1ps

// Channel   Handshake            Payload
// input     push / full          action, key_byte, position
// result    empty / pop          char_out, line_length, cursor_pos, status
//
// The executor finishes a keystroke that edits in place, a clear, or a failed
// read or cursor move in its idle state; a cursor move or an in-range read also
// passes ST_MOVE or ST_RDATA for a registered stack read before write or reply.
// Two-entry queues sit before and after the executor, so input transactions are
// taken while results wait to be popped. Reset clears the counts and queues; the
// stack memories are not cleared and no reset pass is run.

module cursor_line_edit_buffer_top import cleb_pkg::*; #(
    parameter int CAPACITY = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  action,
    input  logic [7:0]  key_byte,
    input  logic [9:0]  position,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  char_out,
    output logic [10:0] line_length,
    output logic [10:0] cursor_pos,
    output logic [1:0]  status
);

    cmd_t cmd;
    logic cmd_valid;
    logic cmd_pop;
    logic res_full;
    logic res_push;
    res_t res_in;
    res_t res_out;
    logic [$bits(res_t)-1:0] res_bits;

    // Front end: decode and queue input transactions.
    cleb_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .action    (action),
        .key_byte  (key_byte),
        .position  (position),
        .full      (full),
        .cmd_pop   (cmd_pop),
        .cmd       (cmd),
        .cmd_valid (cmd_valid)
    );

    // Back end: gap buffer stacks and sequencer.
    cleb_exec #(
        .CAPACITY (CAPACITY)
    ) u_exec (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (res_in)
    );

    // Result queue toward the consumer.
    cleb_fifo #(
        .WIDTH ($bits(res_t))
    ) u_res_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res_in),
        .full  (res_full),
        .pop   (pop),
        .rdata (res_bits),
        .empty (empty)
    );

    assign res_out     = res_t'(res_bits);
    assign char_out    = res_out.char_out;
    assign line_length = res_out.line_length;
    assign cursor_pos  = res_out.cursor_pos;
    assign status      = res_out.status;

    // The executor never pushes a result into a full queue.
    assert property (@(posedge clk) disable iff (!rst_n) res_push |-> !res_full)
        else $error("result pushed into full queue");

    // A command is taken only from a non-empty queue.
    assert property (@(posedge clk) disable iff (!rst_n) cmd_pop |-> cmd_valid)
        else $error("command popped from empty queue");

    // The cursor never lies beyond the end of the line.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> (res_in.cursor_pos <= res_in.line_length))
        else $error("cursor beyond line end");

    // A character is only returned by a successful read.
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_push && res_in.status != STAT_OK) |-> (res_in.char_out == 8'd0))
        else $error("character returned with error status");

endmodule

@@ hw/rtl/cleb_fifo.sv @@
`timescale 1ns / 1ps

module cleb_fifo #(
    parameter int WIDTH = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int DEPTH = 2;

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic             wr_ptr_reg;
    logic             wr_ptr_next;
    logic             rd_ptr_reg;
    logic             rd_ptr_next;
    logic [1:0]       count_reg;
    logic [1:0]       count_next;
    logic             do_push;
    logic             do_pop;

    // A transaction happens on each side only when that side allows it.
    assign full    = (count_reg == 2'(DEPTH));
    assign empty   = (count_reg == 2'd0);
    assign do_push = push & ~full;
    assign do_pop  = pop & ~empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    // Pointer and occupancy update.
    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

@@ hw/rtl/cleb_front.sv @@
`timescale 1ns / 1ps

module cleb_front import cleb_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  logic [1:0] action,
    input  logic [7:0] key_byte,
    input  logic [9:0] position,
    output logic       full,
    input  logic       cmd_pop,
    output cmd_t       cmd,
    output logic       cmd_valid
);

    cmd_t in_cmd;
    logic cmd_empty;
    logic [$bits(cmd_t)-1:0] cmd_bits;

    // Decode the action and keystroke into a single operation.
    always_comb
    begin
        in_cmd.key_byte = key_byte;
        in_cmd.position = position;
        case (action)
            ACT_KEY:
            begin
                case (key_byte)
                    KEY_LEFT:  in_cmd.op = OP_LEFT;
                    KEY_RIGHT: in_cmd.op = OP_RIGHT;
                    KEY_BACK:  in_cmd.op = OP_BACK;
                    default:   in_cmd.op = OP_INSERT;
                endcase
            end
            ACT_READ:  in_cmd.op = OP_READ;
            ACT_CLEAR: in_cmd.op = OP_CLEAR;
            default:   in_cmd.op = OP_NOP;
        endcase
    end

    // Short command queue that decouples intake from execution.
    cleb_fifo #(
        .WIDTH ($bits(cmd_t))
    ) u_cmd_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (in_cmd),
        .full  (full),
        .pop   (cmd_pop),
        .rdata (cmd_bits),
        .empty (cmd_empty)
    );

    assign cmd       = cmd_t'(cmd_bits);
    assign cmd_valid = ~cmd_empty;

endmodule

@@ hw/rtl/cleb_exec.sv @@
`timescale 1ns / 1ps

module cleb_exec import cleb_pkg::*; #(
    parameter int CAPACITY = 1024
) (
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    input  cmd_t cmd,
    output logic cmd_pop,
    input  logic res_full,
    output logic res_push,
    output res_t res
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = (CW > 10) ? CW : 10;
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    // Two stacks of the gap buffer.
    logic [7:0] left_mem  [CAPACITY];
    logic [7:0] right_mem [CAPACITY];

    state_t        state_reg;
    state_t        state_next;
    logic [CW-1:0] left_cnt_reg;
    logic [CW-1:0] left_cnt_next;
    logic [CW-1:0] right_cnt_reg;
    logic [CW-1:0] right_cnt_next;
    op_t           op_reg;
    logic          rd_right_reg;
    logic          rd_right_next;
    logic [7:0]    left_rd_reg;
    logic [7:0]    right_rd_reg;

    logic          left_we;
    logic [AW-1:0] left_waddr;
    logic [7:0]    left_wdata;
    logic          left_re;
    logic [AW-1:0] left_raddr;
    logic          right_we;
    logic [AW-1:0] right_waddr;
    logic [7:0]    right_wdata;
    logic          right_re;
    logic [AW-1:0] right_raddr;

    logic          start;
    logic          can_left;
    logic          can_right;
    logic          is_full;
    logic [XW-1:0] pos_x;
    logic [XW-1:0] left_x;
    logic [XW-1:0] right_x;
    logic [XW-1:0] dist_x;
    logic [XW-1:0] ridx_x;
    logic          in_left;
    logic          in_right;
    logic [CW-1:0] len_next;

    // A command starts only when the result queue has room for its result.
    assign start     = (state_reg == ST_IDLE) && cmd_valid && !res_full;
    assign can_left  = (left_cnt_reg != '0) && (right_cnt_reg != CAP_C);
    assign can_right = (right_cnt_reg != '0) && (left_cnt_reg != CAP_C);
    assign is_full   = ((left_cnt_reg + right_cnt_reg) == CAP_C);

    // Position lookup: left stack in line order, right stack reversed.
    assign pos_x    = XW'(cmd.position);
    assign left_x   = XW'(left_cnt_reg);
    assign right_x  = XW'(right_cnt_reg);
    assign in_left  = (pos_x < left_x);
    assign dist_x   = pos_x - left_x;
    assign in_right = (dist_x < right_x);
    assign ridx_x   = right_x - dist_x - XW'(1);
    assign len_next = left_cnt_next + right_cnt_next;

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if ((cmd.op == OP_LEFT && can_left) ||
                        (cmd.op == OP_RIGHT && can_right))
                    begin
                        state_next = ST_MOVE;
                    end
                    else if (cmd.op == OP_READ && (in_left || in_right))
                    begin
                        state_next = ST_RDATA;
                    end
                end
            end
            ST_MOVE:  state_next = ST_IDLE;
            ST_RDATA: state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Datapath and output logic.
    always_comb
    begin
        cmd_pop        = 1'b0;
        res_push       = 1'b0;
        left_cnt_next  = left_cnt_reg;
        right_cnt_next = right_cnt_reg;
        rd_right_next  = rd_right_reg;
        left_we        = 1'b0;
        left_waddr     = AW'(left_cnt_reg);
        left_wdata     = cmd.key_byte;
        left_re        = 1'b0;
        left_raddr     = AW'(left_cnt_reg - CW'(1));
        right_we       = 1'b0;
        right_waddr    = AW'(right_cnt_reg);
        right_wdata    = left_rd_reg;
        right_re       = 1'b0;
        right_raddr    = AW'(right_cnt_reg - CW'(1));
        res.char_out   = 8'd0;
        res.status     = STAT_OK;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd_pop = 1'b1;
                    case (cmd.op)
                        OP_LEFT:
                        begin
                            left_re  = can_left;
                            res_push = ~can_left;
                        end
                        OP_RIGHT:
                        begin
                            right_re = can_right;
                            res_push = ~can_right;
                        end
                        OP_BACK:
                        begin
                            res_push = 1'b1;
                            if (left_cnt_reg != '0)
                            begin
                                left_cnt_next = left_cnt_reg - CW'(1);
                            end
                        end
                        OP_INSERT:
                        begin
                            res_push = 1'b1;
                            if (is_full)
                            begin
                                res.status = STAT_FULL;
                            end
                            else
                            begin
                                left_we       = 1'b1;
                                left_cnt_next = left_cnt_reg + CW'(1);
                            end
                        end
                        OP_READ:
                        begin
                            left_raddr    = AW'(pos_x);
                            right_raddr   = AW'(ridx_x);
                            rd_right_next = ~in_left;
                            if (in_left)
                            begin
                                left_re = 1'b1;
                            end
                            else if (in_right)
                            begin
                                right_re = 1'b1;
                            end
                            else
                            begin
                                res_push   = 1'b1;
                                res.status = STAT_RANGE;
                            end
                        end
                        OP_CLEAR:
                        begin
                            res_push       = 1'b1;
                            left_cnt_next  = '0;
                            right_cnt_next = '0;
                        end
                        default:
                        begin
                            res_push = 1'b1;
                        end
                    endcase
                end
            end
            ST_MOVE:
            begin
                // The popped byte arrived from memory; push it on the other stack.
                res_push = 1'b1;
                if (op_reg == OP_LEFT)
                begin
                    right_we       = 1'b1;
                    right_wdata    = left_rd_reg;
                    left_cnt_next  = left_cnt_reg - CW'(1);
                    right_cnt_next = right_cnt_reg + CW'(1);
                end
                else
                begin
                    left_we        = 1'b1;
                    left_wdata     = right_rd_reg;
                    left_cnt_next  = left_cnt_reg + CW'(1);
                    right_cnt_next = right_cnt_reg - CW'(1);
                end
            end
            ST_RDATA:
            begin
                res_push     = 1'b1;
                res.char_out = rd_right_reg ? right_rd_reg : left_rd_reg;
            end
            default:
            begin
                res_push = 1'b0;
            end
        endcase
        res.line_length = 11'(len_next);
        res.cursor_pos  = 11'(left_cnt_next);
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            left_cnt_reg  <= '0;
            right_cnt_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            left_cnt_reg  <= left_cnt_next;
            right_cnt_reg <= right_cnt_next;
        end
    end

    // Operation held across the memory read.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            op_reg <= cmd.op;
        end
        rd_right_reg <= rd_right_next;
    end

    // Left stack memory with registered read data.
    always_ff @(posedge clk)
    begin
        if (left_we)
        begin
            left_mem[left_waddr] <= left_wdata;
        end
        if (left_re)
        begin
            left_rd_reg <= left_mem[left_raddr];
        end
    end

    // Right stack memory with registered read data.
    always_ff @(posedge clk)
    begin
        if (right_we)
        begin
            right_mem[right_waddr] <= right_wdata;
        end
        if (right_re)
        begin
            right_rd_reg <= right_mem[right_raddr];
        end
    end

endmodule
